@@ sv/prdj_pkg.sv @@
// Shared types, constants and helper functions for the planar rocket dynamics block.
// Depends on nothing; every other file imports it.
package prdj_pkg;

	localparam int MAX_STAGES = 24;

	localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
	localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
	localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;
	localparam logic signed [32:0] GAIN_Q30    = 33'sd652032874;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_THRUST_TO_WEIGHT = 2'd0;
	localparam reg_idx_t REG_GRAVITY          = 2'd1;
	localparam reg_idx_t REG_TORQUE_COEFF     = 2'd2;

	localparam logic [15:0] THRUST_TO_WEIGHT_RST = 16'd512;
	localparam logic [15:0] GRAVITY_RST          = 16'd2511;
	localparam logic [23:0] TORQUE_COEFF_RST     = 24'd65536;

	typedef struct packed {
		logic        [15:0] throttle;
		logic signed [15:0] gimbal_angle;
		logic signed [15:0] pitch_angle;
	} item_t;

	typedef struct packed {
		logic signed [31:0] accel_x;
		logic signed [31:0] accel_y;
		logic signed [31:0] angular_accel;
		logic signed [31:0] dax_dthrottle;
		logic signed [31:0] dax_dgimbal;
		logic signed [31:0] day_dthrottle;
		logic signed [31:0] day_dgimbal;
		logic signed [31:0] dalpha_dthrottle;
		logic signed [31:0] dalpha_dgimbal;
	} result_t;

	// per-item sideband carried alongside the CORDIC stages
	typedef struct packed {
		logic [15:0] u;
		logic [31:0] tg;
		logic [39:0] tgr;
	} side_t;

	function automatic logic signed [32:0] atan_q30(input int i);
		logic signed [32:0] a;
		case (i)
			0:  a = 33'sh03243F6A8;
			1:  a = 33'sh01DAC6705;
			2:  a = 33'sh00FADBAFC;
			3:  a = 33'sh007F56EA6;
			4:  a = 33'sh003FEAB76;
			5:  a = 33'sh001FFD55B;
			6:  a = 33'sh000FFFAAA;
			7:  a = 33'sh0007FFF55;
			8:  a = 33'sh0003FFFEA;
			9:  a = 33'sh0001FFFFD;
			10: a = 33'sh0000FFFFF;
			11: a = 33'sh00007FFFF;
			12: a = 33'sh00003FFFF;
			13: a = 33'sh00001FFFF;
			14: a = 33'sh00000FFFF;
			15: a = 33'sh000007FFF;
			16: a = 33'sh000003FFF;
			17: a = 33'sh000001FFF;
			18: a = 33'sh000000FFF;
			19: a = 33'sh0000007FF;
			20: a = 33'sh0000003FF;
			21: a = 33'sh0000001FF;
			22: a = 33'sh0000000FF;
			23: a = 33'sh00000007F;
			default: a = 33'sd0;
		endcase
		return a;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		logic signed [31:0] r;
		if (v > 48'sd2147483647)
			r = 32'sh7FFFFFFF;
		else if (v < -48'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

@@ sv/planar_rocket_dynamics_jacobian.sv @@
// Top level of the planar rocket dynamics and control Jacobian pipeline.
// Depends on prdj_pkg, prdj_cordic and prdj_post.
//
//   channel   signals                        handshake
//   -------   ----------------------------   ------------------------------
//   item      start, busy, item              beat when start && !busy
//   result    done, result                   one-cycle strobe, no backpressure
//   config    cfg_we, cfg_idx, cfg_data      write when cfg_we
//
// One item per cycle. From the accepting edge to the done cycle an item passes one
// range-reduction stage, one stage per CORDIC iteration and three product stages.
// busy stays low; the pipeline never stalls.
// arst_n clears the valid bits and loads the register reset values.
module planar_rocket_dynamics_jacobian #(
	parameter int SINCOS_STAGES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  prdj_pkg::item_t   item,
	output logic              done,
	output prdj_pkg::result_t result,
	input  logic              cfg_we,
	input  prdj_pkg::reg_idx_t cfg_idx,
	input  logic [23:0]       cfg_data
);
	import prdj_pkg::*;

	localparam int NS = (SINCOS_STAGES < MAX_STAGES) ? SINCOS_STAGES : MAX_STAGES;

	logic [15:0] thrust_to_weight_q, gravity_q;
	logic [23:0] torque_coeff_q;

	logic               accept;
	logic signed [16:0] ang_sum, ang_gim;
	logic [55:0]        tgr_prod;
	side_t              side_s [NS+1];

	logic               vld_a, vld_b;
	logic signed [32:0] s1, c1, sg, cg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thrust_to_weight_q <= THRUST_TO_WEIGHT_RST;
			gravity_q          <= GRAVITY_RST;
			torque_coeff_q     <= TORQUE_COEFF_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_THRUST_TO_WEIGHT: thrust_to_weight_q <= cfg_data[15:0];
				REG_GRAVITY:          gravity_q          <= cfg_data[15:0];
				REG_TORQUE_COEFF:     torque_coeff_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy    = 1'b0;
	assign accept  = start && !busy;
	assign ang_gim = {item.gimbal_angle[15], item.gimbal_angle};
	assign ang_sum = ang_gim + {item.pitch_angle[15], item.pitch_angle};

	always_ff @(posedge clk) begin
		side_s[0].u   <= item.throttle;
		side_s[0].tg  <= {16'd0, thrust_to_weight_q} * {16'd0, gravity_q};
		side_s[0].tgr <= 40'd0;
	end

	assign tgr_prod = {24'd0, side_s[0].tg} * {32'd0, torque_coeff_q};

	always_ff @(posedge clk) begin
		side_s[1].u   <= side_s[0].u;
		side_s[1].tg  <= side_s[0].tg;
		side_s[1].tgr <= 40'((tgr_prod + 56'd32768) >> 16);
	end

	for (genvar k = 1; k < NS; k++) begin : g_side
		always_ff @(posedge clk) begin
			side_s[k+1] <= side_s[k];
		end
	end

	prdj_cordic #(.NS(NS)) u_cordic_sum (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (accept),
		.angle   (ang_sum),
		.vld_out (vld_a),
		.sin_out (s1),
		.cos_out (c1)
	);

	prdj_cordic #(.NS(NS)) u_cordic_gim (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (accept),
		.angle   (ang_gim),
		.vld_out (vld_b),
		.sin_out (sg),
		.cos_out (cg)
	);

	prdj_post u_post (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (vld_a && vld_b),
		.side    (side_s[NS]),
		.s1      (s1),
		.c1      (c1),
		.sg      (sg),
		.cg      (cg),
		.gravity (gravity_q),
		.vld_out (done),
		.res     (result)
	);

endmodule

@@ sv/prdj_cordic.sv @@
// Pipelined rotation-mode CORDIC: range reduction stage then one stage per iteration.
// Depends on prdj_pkg.
module prdj_cordic #(
	parameter int NS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld_in,
	input  logic signed [16:0] angle,
	output logic               vld_out,
	output logic signed [32:0] sin_out,
	output logic signed [32:0] cos_out
);
	import prdj_pkg::*;

	logic signed [34:0] z_in, z_red, z_fold;
	logic               flip_in;

	logic               vld_s  [NS+1];
	logic               flip_s [NS+1];
	logic signed [32:0] x_s    [NS+1];
	logic signed [32:0] y_s    [NS+1];
	logic signed [32:0] z_s    [NS+1];

	always_comb begin
		z_in = {angle[16], angle, 17'd0};
		if (z_in > PI_Q30)
			z_red = z_in - TWO_PI_Q30;
		else if (z_in < -PI_Q30)
			z_red = z_in + TWO_PI_Q30;
		else
			z_red = z_in;
		if (z_red > HALF_PI_Q30) begin
			z_fold  = z_red - PI_Q30;
			flip_in = 1'b1;
		end else if (z_red < -HALF_PI_Q30) begin
			z_fold  = z_red + PI_Q30;
			flip_in = 1'b1;
		end else begin
			z_fold  = z_red;
			flip_in = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s[0] <= 1'b0;
		else
			vld_s[0] <= vld_in;
	end

	always_ff @(posedge clk) begin
		x_s[0]    <= GAIN_Q30;
		y_s[0]    <= 33'sd0;
		z_s[0]    <= z_fold[32:0];
		flip_s[0] <= flip_in;
	end

	for (genvar k = 0; k < NS; k++) begin : g_iter
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			flip_s[k+1] <= flip_s[k];
			if (!z_s[k][32]) begin
				x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
				y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
				z_s[k+1] <= z_s[k] - atan_q30(k);
			end else begin
				x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
				y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
				z_s[k+1] <= z_s[k] + atan_q30(k);
			end
		end
	end

	assign vld_out = vld_s[NS];
	assign sin_out = flip_s[NS] ? -y_s[NS] : y_s[NS];
	assign cos_out = flip_s[NS] ? -x_s[NS] : x_s[NS];

endmodule

@@ sv/prdj_post.sv @@
// Product, rounding and saturation stages that turn sines and cosines into results.
// Depends on prdj_pkg.
module prdj_post (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld_in,
	input  prdj_pkg::side_t    side,
	input  logic signed [32:0] s1,
	input  logic signed [32:0] c1,
	input  logic signed [32:0] sg,
	input  logic signed [32:0] cg,
	input  logic        [15:0] gravity,
	output logic               vld_out,
	output prdj_pkg::result_t  res
);
	import prdj_pkg::*;

	logic signed [65:0] ps, pc, psr, pcr;
	logic signed [52:0] pus, puc;
	logic signed [60:0] pur, puc2;

	logic               vld_s1, vld_s2, vld_s3;
	logic        [15:0] u_s1, u_s2;
	logic        [39:0] tgr_s1;
	logic signed [35:0] sgv_s1, cgv_s1, sgv_s2, cgv_s2;
	logic signed [24:0] sgq_s1, cgq_s1;
	logic signed [43:0] sr_s2, cr_s2;
	logic signed [37:0] usg_s2, ucg_s2;
	logic signed [45:0] usr, ucr;
	result_t            res_s3;

	always_comb begin
		ps   = $signed({1'b0, side.tg}) * s1;
		pc   = $signed({1'b0, side.tg}) * c1;
		psr  = $signed({1'b0, tgr_s1}) * sgq_s1;
		pcr  = $signed({1'b0, tgr_s1}) * cgq_s1;
		pus  = $signed({1'b0, u_s1}) * sgv_s1;
		puc  = $signed({1'b0, u_s1}) * cgv_s1;
		pur  = $signed({1'b0, u_s2}) * sr_s2;
		puc2 = $signed({1'b0, u_s2}) * cr_s2;
		usr  = 46'((pur + 61'sd16384) >>> 15);
		ucr  = 46'((puc2 + 61'sd16384) >>> 15);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		u_s1   <= side.u;
		tgr_s1 <= side.tgr;
		sgv_s1 <= 36'((ps + 66'sd536870912) >>> 30);
		cgv_s1 <= 36'((pc + 66'sd536870912) >>> 30);
		sgq_s1 <= 25'((sg + 33'sd128) >>> 8);
		cgq_s1 <= 25'((cg + 33'sd128) >>> 8);

		u_s2   <= u_s1;
		sgv_s2 <= sgv_s1;
		cgv_s2 <= cgv_s1;
		sr_s2  <= 44'((psr + 66'sd2097152) >>> 22);
		cr_s2  <= 44'((pcr + 66'sd2097152) >>> 22);
		usg_s2 <= 38'((pus + 53'sd16384) >>> 15);
		ucg_s2 <= 38'((puc + 53'sd16384) >>> 15);

		res_s3.accel_x          <= sat32(48'(usg_s2));
		res_s3.accel_y          <= sat32(48'(ucg_s2) - $signed({24'd0, gravity, 8'd0}));
		res_s3.angular_accel    <= sat32(-48'(usr));
		res_s3.dax_dthrottle    <= sat32(48'(sgv_s2));
		res_s3.dax_dgimbal      <= sat32(48'(ucg_s2));
		res_s3.day_dthrottle    <= sat32(48'(cgv_s2));
		res_s3.day_dgimbal      <= sat32(-48'(usg_s2));
		res_s3.dalpha_dthrottle <= sat32(-48'(sr_s2));
		res_s3.dalpha_dgimbal   <= sat32(-48'(ucr));
	end

	assign vld_out = vld_s3;
	assign res     = res_s3;

endmodule

@@ sv/prdj_checker.sv @@
// Port-level checks on the item and result channels, bound to the top level.
// Depends on prdj_pkg and planar_rocket_dynamics_jacobian.
module prdj_checker #(
	parameter int SINCOS_STAGES = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);
	import prdj_pkg::*;

	localparam int LAT = ((SINCOS_STAGES < MAX_STAGES) ? SINCOS_STAGES : MAX_STAGES) + 4;

	a_beat_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted beat produced no result");

	a_result_has_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without matching beat");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

endmodule

bind planar_rocket_dynamics_jacobian prdj_checker #(.SINCOS_STAGES(SINCOS_STAGES)) u_prdj_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
